### hdl/ara_pkg.sv
package ara_pkg;
    localparam int unsigned FreeEntriesDefault = 256;
    localparam int unsigned CoordBitsDefault   = 13;
    localparam int unsigned ReqBits            = 14;
    localparam int unsigned EdgeBits           = 14;
    localparam int unsigned StatusBits         = 3;
    localparam int unsigned PosBits            = 13;
    localparam logic [EdgeBits-1:0] EdgeReset  = 14'd2048;

    localparam logic [StatusBits-1:0] StPlaced  = 3'd0;
    localparam logic [StatusBits-1:0] StWiped   = 3'd1;
    localparam logic [StatusBits-1:0] StTooBig  = 3'd2;
    localparam logic [StatusBits-1:0] StInvalid = 3'd3;
    localparam logic [StatusBits-1:0] StCleared = 3'd4;

    localparam logic OpAlloc = 1'b0;
    localparam logic OpClear = 1'b1;
endpackage

### hdl/ara_if.sv
interface ara_req_if;
    import ara_pkg::*;
    logic                valid;
    logic                ready;
    logic                op;
    logic [ReqBits-1:0]  req_width;
    logic [ReqBits-1:0]  req_height;
    modport source (output valid, op, req_width, req_height, input ready);
    modport sink   (input valid, op, req_width, req_height, output ready);
endinterface

interface ara_res_if;
    import ara_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [StatusBits-1:0] status;
    logic [PosBits-1:0]    pos_x;
    logic [PosBits-1:0]    pos_y;
    logic                  fragment_lost;
    modport source (output valid, status, pos_x, pos_y, fragment_lost, input ready);
    modport sink   (input valid, status, pos_x, pos_y, fragment_lost, output ready);
endinterface

interface ara_cfg_if;
    import ara_pkg::*;
    logic                valid;
    logic                ready;
    logic [EdgeBits-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### hdl/atlas_rect_allocator_unit.sv
// Atlas rectangle allocator: guillotine best-fit placement in a square atlas.
// Channels: i_req (op, req_width, req_height), o_res (status, pos_x, pos_y,
// fragment_lost), i_cfg (atlas_edge write data). All are valid/ready; a beat
// moves when both are high. One result beat per request beat.
// The free table sits in one single-port-read, one-write synchronous memory
// of FREE_ENTRIES words (valid, stamp, x, y, w, h). An allocation sweeps the
// table once, and after a failed search sweeps it again through a wipe and a
// second search. Piece write-back looks for the lowest free slot with a sweep
// per piece that stops at the first free entry. Clear wipes the table and then
// answers; invalid requests and those larger than the atlas edge are answered
// from the size check without a sweep. One request is in work at a time.
// After reset the block runs a clearing pass that writes the whole atlas to
// entry zero and empties the rest; no request is taken meanwhile,
// configuration writes are. A result is held in the output register while the
// receiver stalls; the next request is taken only after that result has gone.
module atlas_rect_allocator_unit
    import ara_pkg::*;
#(
    parameter int unsigned FREE_ENTRIES = FreeEntriesDefault,
    parameter int unsigned COORD_BITS   = CoordBitsDefault
) (
    input logic    i_clk,
    input logic    i_rst_n,
    ara_req_if.sink   i_req,
    ara_res_if.source o_res,
    ara_cfg_if.sink   i_cfg
);
    localparam int unsigned IB = $clog2(FREE_ENTRIES);
    localparam int unsigned CB = IB + 1;
    localparam int unsigned DB = COORD_BITS + 1;
    localparam int unsigned RB = 4 * DB + 1 + 32;
    localparam logic [DB-1:0] Lim = DB'(1) << COORD_BITS;

    typedef enum logic [3:0] {
        S_WIPE, S_IDLE, S_CHECK, S_SCAN, S_FETCH, S_FETCHW, S_SPLIT,
        S_FIND, S_PUT, S_DONE
    } t_state;

    t_state          r_state;
    logic [EdgeBits-1:0] r_edge;
    logic [IB:0]     r_cnt;
    logic            r_op;
    logic [DB-1:0]   r_pw, r_ph;
    logic [ReqBits-1:0] r_rw, r_rh;
    logic            r_retry, r_wipe_then_scan, r_rdv;
    logic [IB-1:0]   r_rdi;
    logic            r_bwv, r_bhv;
    logic [IB-1:0]   r_bwi, r_bhi;
    logic [DB-1:0]   r_kw, r_kh;
    logic [31:0]     r_sw, r_sh;
    logic [31:0]     r_ins;
    logic [DB-1:0]   r_cx, r_cy, r_cw, r_ch;
    logic [DB-1:0]   r_px [2], r_py [2], r_pw2 [2], r_ph2 [2];
    logic            r_pi;
    logic            r_lost;
    logic            r_ovalid;
    logic [StatusBits-1:0] r_status;
    logic [PosBits-1:0] r_x, r_y;

    logic            we;
    logic [IB-1:0]   waddr, raddr;
    logic [RB-1:0]   wdata, rdata;
    logic [DB-1:0]   e_now;
    logic            rv;
    logic [31:0]     rs;
    logic [DB-1:0]   rx, ry, rw, rh;

    ara_table #(.FREE_ENTRIES(FREE_ENTRIES), .COORD_BITS(COORD_BITS),
                .IDX_BITS(IB), .RECT_BITS(RB)) u_table (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    assign {rv, rs, rx, ry, rw, rh} = rdata;
    assign e_now = ({1'b0, r_edge} > {1'b0, EdgeBits'(Lim)}) ? Lim : DB'(r_edge);
    assign i_req.ready = (r_state == S_IDLE) && !r_ovalid;
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = r_ovalid;
    assign o_res.status = r_status;
    assign o_res.pos_x = r_x;
    assign o_res.pos_y = r_y;
    assign o_res.fragment_lost = r_lost;

    // memory port control
    always_comb begin
        we = 1'b0;
        waddr = r_cnt[IB-1:0];
        wdata = '0;
        raddr = r_cnt[IB-1:0];
        case (r_state)
            S_WIPE: begin
                we = 1'b1;
                if (r_cnt == '0 && e_now != '0) begin
                    wdata = {1'b1, 32'd0, DB'(0), DB'(0), e_now, e_now};
                end
            end
            S_FETCH: raddr = (r_bwv && (!r_bhv || (r_kw - r_pw) <= (r_kh - r_ph)))
                             ? r_bwi : r_bhi;
            S_SPLIT: begin
                we = 1'b1;
                waddr = r_rdi;
                wdata = '0;
            end
            S_PUT: begin
                we = r_rdv && !rv;
                waddr = r_rdi;
                wdata = {1'b1, r_ins, r_px[r_pi], r_py[r_pi], r_pw2[r_pi], r_ph2[r_pi]};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_WIPE;
            r_cnt <= '0;
            r_edge <= EdgeReset;
            r_ovalid <= 1'b0;
            r_ins <= 32'd1;
            r_retry <= 1'b0;
            r_wipe_then_scan <= 1'b0;
            r_rdv <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_edge <= i_cfg.data;
            end
            if (r_ovalid && o_res.ready) begin
                r_ovalid <= 1'b0;
            end
            r_rdv <= 1'b0;
            case (r_state)
                S_WIPE: begin
                    r_ins <= 32'd1;
                    if (r_cnt == CB'(FREE_ENTRIES - 1)) begin
                        r_cnt <= '0;
                        if (r_wipe_then_scan) begin
                            r_wipe_then_scan <= 1'b0;
                            r_state <= S_SCAN;
                            r_bwv <= 1'b0;
                            r_bhv <= 1'b0;
                        end else if (r_op == OpClear && r_retry) begin
                            r_retry <= 1'b0;
                            r_status <= StCleared;
                            r_x <= '0;
                            r_y <= '0;
                            r_lost <= 1'b0;
                            r_ovalid <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_req.valid && i_req.ready) begin
                        r_op <= i_req.op;
                        r_rw <= i_req.req_width;
                        r_rh <= i_req.req_height;
                        r_cnt <= '0;
                        r_retry <= 1'b0;
                        r_lost <= 1'b0;
                        if (i_req.op == OpClear) begin
                            r_retry <= 1'b1;
                            r_state <= S_WIPE;
                        end else begin
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_CHECK: begin
                    r_x <= '0;
                    r_y <= '0;
                    r_pw <= DB'(r_rw);
                    r_ph <= DB'(r_rh);
                    r_bwv <= 1'b0;
                    r_bhv <= 1'b0;
                    if (((r_rw > r_rh) ? r_rw : r_rh) > ReqBits'(e_now)) begin
                        r_status <= StTooBig;
                        r_ovalid <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (r_rw == '0 || r_rh == '0) begin
                        r_status <= StInvalid;
                        r_ovalid <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_status <= StPlaced;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_cnt != CB'(FREE_ENTRIES)) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    r_rdv <= (r_cnt != CB'(FREE_ENTRIES));
                    r_rdi <= r_cnt[IB-1:0];
                    if (r_rdv && rv) begin
                        if (rw > rh) begin
                            if (rh >= r_ph && rw >= r_pw &&
                                (!r_bhv || rh < r_kh || (rh == r_kh && rs < r_sh))) begin
                                r_bhv <= 1'b1; r_bhi <= r_rdi; r_kh <= rh; r_sh <= rs;
                            end
                        end else begin
                            if (rw >= r_pw && rh >= r_ph &&
                                (!r_bwv || rw < r_kw || (rw == r_kw && rs < r_sw))) begin
                                r_bwv <= 1'b1; r_bwi <= r_rdi; r_kw <= rw; r_sw <= rs;
                            end
                        end
                    end
                    if (!r_rdv && r_cnt == CB'(FREE_ENTRIES)) begin
                        r_cnt <= '0;
                        if (r_bwv || r_bhv) begin
                            r_state <= S_FETCH;
                        end else if (!r_retry) begin
                            r_retry <= 1'b1;
                            r_status <= StWiped;
                            r_wipe_then_scan <= 1'b1;
                            r_state <= S_WIPE;
                        end else begin
                            r_status <= StTooBig;
                            r_ovalid <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_FETCH: begin
                    r_rdi <= raddr;
                    r_state <= S_FETCHW;
                end
                S_FETCHW: begin
                    r_cx <= rx; r_cy <= ry; r_cw <= rw; r_ch <= rh;
                    r_state <= S_SPLIT;
                end
                S_SPLIT: begin
                    r_x <= PosBits'(r_cx);
                    r_y <= PosBits'(r_cy);
                    r_px[0] <= r_cx + r_pw; r_py[0] <= r_cy; r_pw2[0] <= r_cw - r_pw;
                    r_px[1] <= r_cx; r_py[1] <= r_cy + r_ph; r_ph2[1] <= r_ch - r_ph;
                    if ((r_cw - r_pw) > (r_ch - r_ph)) begin
                        r_ph2[0] <= r_ch; r_pw2[1] <= r_pw;
                    end else begin
                        r_ph2[0] <= r_ph; r_pw2[1] <= r_cw;
                    end
                    r_pi <= 1'b0;
                    r_cnt <= '0;
                    r_state <= S_FIND;
                end
                S_FIND: begin
                    if (r_pw2[r_pi] == '0 || r_ph2[r_pi] == '0) begin
                        if (r_pi) begin
                            r_state <= S_DONE;
                        end else begin
                            r_pi <= 1'b1;
                        end
                    end else begin
                        r_cnt <= '0;
                        r_state <= S_PUT;
                    end
                end
                S_PUT: begin
                    if (r_cnt != CB'(FREE_ENTRIES)) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    r_rdv <= (r_cnt != CB'(FREE_ENTRIES));
                    r_rdi <= r_cnt[IB-1:0];
                    if (r_rdv && !rv) begin
                        r_ins <= r_ins + 32'd1;
                        r_rdv <= 1'b0;
                        r_cnt <= '0;
                        if (r_pi) r_state <= S_DONE;
                        else begin
                            r_pi <= 1'b1;
                            r_state <= S_FIND;
                        end
                    end else if (!r_rdv && r_cnt == CB'(FREE_ENTRIES)) begin
                        r_lost <= 1'b1;
                        r_cnt <= '0;
                        if (r_pi) r_state <= S_DONE;
                        else begin
                            r_pi <= 1'b1;
                            r_state <= S_FIND;
                        end
                    end
                end
                S_DONE: begin
                    r_ovalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### hdl/ara_table.sv
module ara_table
    import ara_pkg::*;
#(
    parameter int unsigned FREE_ENTRIES = FreeEntriesDefault,
    parameter int unsigned COORD_BITS   = CoordBitsDefault,
    parameter int unsigned IDX_BITS     = $clog2(FREE_ENTRIES),
    parameter int unsigned RECT_BITS    = 4 * (COORD_BITS + 1) + 1 + 32
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [IDX_BITS-1:0]  i_waddr,
    input  logic [RECT_BITS-1:0] i_wdata,
    input  logic [IDX_BITS-1:0]  i_raddr,
    output logic [RECT_BITS-1:0] o_rdata
);
    logic [RECT_BITS-1:0] r_mem [FREE_ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### hdl/ara_checker.sv
module ara_checker
    import ara_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  req_valid,
    input logic                  req_ready,
    input logic                  res_valid,
    input logic                  res_ready,
    input logic [StatusBits-1:0] status,
    input logic [PosBits-1:0]    pos_x,
    input logic [PosBits-1:0]    pos_y,
    input logic                  lost
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && !res_ready |=> res_valid && $stable(status))
        else $error("result dropped under stall");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> !req_ready)
        else $error("request taken with result pending");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && (status == StTooBig || status == StInvalid || status == StCleared)
        |-> pos_x == '0 && pos_y == '0 && !lost)
        else $error("non-placed result carries data");
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> status <= StCleared)
        else $error("bad status");
endmodule

bind atlas_rect_allocator_unit ara_checker u_ara_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .req_valid(i_req.valid), .req_ready(i_req.ready),
    .res_valid(o_res.valid), .res_ready(o_res.ready),
    .status(o_res.status), .pos_x(o_res.pos_x), .pos_y(o_res.pos_y),
    .lost(o_res.fragment_lost)
);
